>>> rtl/core/mfsk_continuous_phase_modulator_assert.svh
// Assertion macros used by the modulator port checker
`ifndef MFSK_CONTINUOUS_PHASE_MODULATOR_ASSERT_SVH
`define MFSK_CONTINUOUS_PHASE_MODULATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MFSK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfsk assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define MFSK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfsk assertion failed");

`endif

>>> rtl/core/mfsk_pkg.sv
// Shared types and constants of the MFSK modulator
`timescale 1ns / 1ps
package mfsk_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TONE_STEP = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NUM_TONES = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AMPLITUDE = 8'd3;

  // Register reset values
  localparam logic [31:0] RST_BASE_STEP = 32'd89478485;
  localparam logic [31:0] RST_TONE_STEP = 32'd134217728;
  localparam logic [4:0]  RST_NUM_TONES = 5'd16;
  localparam logic [14:0] RST_AMPLITUDE = 15'd32767;

  // Quarter-wave sine polynomial coefficients (Q15)
  localparam logic [11:0] SIN_C3  = 12'd2611;
  localparam logic [14:0] SIN_C2  = 15'd21167;
  localparam logic [15:0] SIN_C1  = 16'd51472;
  localparam logic [14:0] Q15_MAX = 15'h7FFF;
  localparam logic [14:0] Q15_RND = 15'd16384;

  typedef struct packed {
    logic [31:0] base_phase_step;
    logic [31:0] tone_step;
    logic [4:0]  tone_count;
    logic [14:0] amplitude;
  } mfsk_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_step;
    logic       issue;
    logic       last;
    logic [3:0] sym;
  } mfsk_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic adv;
  } mfsk_stat_t;

endpackage

>>> rtl/core/mfsk_if.sv
// Handshake channel interfaces of the MFSK modulator
`timescale 1ns / 1ps

interface mfsk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface mfsk_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [3:0]         tone_index;
  logic               last;
  modport source (output valid, output sample, output tone_index, output last, input ready);
  modport sink (input valid, input sample, input tone_index, input last, output ready);
endinterface

interface mfsk_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/mfsk_cfg_regs.sv
// Configuration register file of the MFSK modulator
`timescale 1ns / 1ps
module mfsk_cfg_regs
  import mfsk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_idx,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output mfsk_cfg_t             cfg
);

  mfsk_cfg_t cfg_r;

  // Decode writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_phase_step <= RST_BASE_STEP;
      cfg_r.tone_step       <= RST_TONE_STEP;
      cfg_r.tone_count      <= RST_NUM_TONES;
      cfg_r.amplitude       <= RST_AMPLITUDE;
    end else if (wr_en) begin
      unique case (wr_idx)
        CFG_IDX_BASE_STEP: cfg_r.base_phase_step <= wr_data;
        CFG_IDX_TONE_STEP: cfg_r.tone_step       <= wr_data;
        CFG_IDX_NUM_TONES: cfg_r.tone_count      <= wr_data[4:0];
        CFG_IDX_AMPLITUDE: cfg_r.amplitude       <= wr_data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/mfsk_ctrl.sv
// Symbol sequencer: splits a byte into nibbles and paces the samples
`timescale 1ns / 1ps
module mfsk_ctrl
  import mfsk_pkg::*;
#(
  parameter int SAMPLES_PER_SYMBOL_P = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic [4:0] tone_count,
  input  mfsk_stat_t stat,
  output mfsk_cmd_t  cmd
);

  localparam int CNT_W = (SAMPLES_PER_SYMBOL_P > 1) ? $clog2(SAMPLES_PER_SYMBOL_P) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_SYMBOL_P - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_RUN} state_t;

  state_t           state_r;
  logic [7:0]       byte_r;
  logic             half_r;
  logic [CNT_W-1:0] cnt_r;
  logic [3:0]       sym_r;
  logic [3:0]       nib;
  logic [3:0]       sym_nxt;
  logic             cnt_end;

  // Map the current nibble; out-of-range symbols fall to tone zero
  assign nib     = half_r ? byte_r[3:0] : byte_r[7:4];
  assign sym_nxt = ({1'b0, nib} >= tone_count) ? 4'd0 : nib;
  assign cnt_end = (cnt_r == CNT_LAST);

  assign in_ready      = (state_r == ST_IDLE);
  assign cmd.load_step = (state_r == ST_LOAD);
  assign cmd.issue     = (state_r == ST_RUN) && stat.adv;
  assign cmd.last      = half_r && cnt_end;
  assign cmd.sym       = (state_r == ST_LOAD) ? sym_nxt : sym_r;

  // Sequence: take byte, load step per nibble, issue the samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      half_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            byte_r  <= in_byte;
            half_r  <= 1'b0;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          sym_r   <= sym_nxt;
          cnt_r   <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          if (stat.adv) begin
            if (cnt_end) begin
              if (half_r) begin
                state_r <= ST_IDLE;
              end else begin
                half_r  <= 1'b1;
                state_r <= ST_LOAD;
              end
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/mfsk_dp.sv
// Phase accumulator and pipelined sine, scale and round datapath
`timescale 1ns / 1ps
module mfsk_dp
  import mfsk_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mfsk_cfg_t          cfg,
  input  mfsk_cmd_t          cmd,
  output mfsk_stat_t         stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [15:0] out_sample,
  output logic [3:0]         out_tone,
  output logic               out_last
);

  localparam int STB  = SINE_TABLE_BITS;
  localparam int QLEN = 1 << (STB - 2);

  typedef struct packed {
    logic       neg;
    logic [3:0] sym;
    logic       last;
  } tag_t;

  logic [31:0]    phase_r;
  logic [31:0]    step_r;
  logic [31:0]    step_nxt;
  logic           adv;

  logic [STB-1:0] idx;
  logic [STB-3:0] qr;
  logic [STB-2:0] xpos;
  logic [16:0]    xq_nxt;

  logic           s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_v_r;
  tag_t           tag1_r, tag2_r, tag3_r, tag4_r, tag5_r, tag6_r;
  logic [16:0]    xq1_r, xq2_r, xq3_r, xq4_r;
  logic [15:0]    x2_2_r, x2_3_r;
  logic [14:0]    t1_r;
  logic [15:0]    t2_r;
  logic [14:0]    y_r;
  logic [29:0]    prod_r;

  logic [33:0]    p2;
  logic [27:0]    p3;
  logic [30:0]    p4;
  logic [32:0]    p5;
  logic [17:0]    y_wide;
  logic [30:0]    rnd;
  logic [15:0]    mag_full;
  logic [14:0]    mag;

  logic signed [15:0] sample_r;
  logic [3:0]         tone_r;
  logic               last_r;

  // Whole pipeline moves when the output register is free or drained
  assign adv      = !out_v_r || out_ready;
  assign stat.adv = adv;

  // Step for the coming symbol
  assign step_nxt = cfg.base_phase_step + cfg.tone_step * 32'(cmd.sym);

  // Hold phase and step; advance phase by one step per issued sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.issue) begin
      phase_r <= phase_r + step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_step) begin
      step_r <= step_nxt;
    end
  end

  // Quarter-wave position of the current phase, scaled to Q15
  assign idx    = phase_r[31 -: STB];
  assign qr     = idx[STB-3:0];
  assign xpos   = idx[STB-2] ? ((STB-1)'(QLEN) - {1'b0, qr}) : {1'b0, qr};
  assign xq_nxt = 17'(xpos) << (17 - STB);

  // Stage products, one multiplier each
  assign p2     = 34'(xq1_r) * 34'(xq1_r);
  assign p3     = 28'(SIN_C3) * 28'(x2_2_r);
  assign p4     = 31'(t1_r) * 31'(x2_3_r);
  assign p5     = 33'(t2_r) * 33'(xq4_r);
  assign y_wide = p5[32:15];

  // Round, saturate and sign at the output
  assign rnd      = 31'(prod_r) + 31'(Q15_RND);
  assign mag_full = rnd[30:15];
  assign mag      = mag_full[15] ? Q15_MAX : mag_full[14:0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= cmd.issue;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      out_v_r <= s6_v_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      xq1_r       <= xq_nxt;
      tag1_r.neg  <= idx[STB-1];
      tag1_r.sym  <= cmd.sym;
      tag1_r.last <= cmd.last;

      x2_2_r <= p2[30:15];
      xq2_r  <= xq1_r;
      tag2_r <= tag1_r;

      t1_r   <= 15'(17'(SIN_C2) - 17'(p3[27:15]));
      x2_3_r <= x2_2_r;
      xq3_r  <= xq2_r;
      tag3_r <= tag2_r;

      t2_r   <= 16'(17'(SIN_C1) - 17'(p4[30:15]));
      xq4_r  <= xq3_r;
      tag4_r <= tag3_r;

      y_r    <= (y_wide > 18'(Q15_MAX)) ? Q15_MAX : y_wide[14:0];
      tag5_r <= tag4_r;

      prod_r <= 30'(y_r) * 30'(cfg.amplitude);
      tag6_r <= tag5_r;

      sample_r <= tag6_r.neg ? $signed(16'd0 - {1'b0, mag}) : $signed({1'b0, mag});
      tone_r   <= tag6_r.sym;
      last_r   <= tag6_r.last;
    end
  end

  assign out_valid  = out_v_r;
  assign out_sample = sample_r;
  assign out_tone   = tone_r;
  assign out_last   = last_r;

endmodule

>>> rtl/core/mfsk_continuous_phase_modulator.sv
// Top level of the continuous-phase 16-tone MFSK modulator
// The first sample of a byte passes a step load, then stages s1 to s6 and the output register.
// Per byte: an accept state, a step load per symbol, then one sample issued per cycle while
//   the output does not stall.
// A new byte is taken once the previous one has issued all samples into the pipeline.
// Reset (synchronous, rst_n low) loads default registers, clears phase and pipeline.
`timescale 1ns / 1ps
module mfsk_continuous_phase_modulator
  import mfsk_pkg::*;
#(
  parameter int SAMPLES_PER_SYMBOL_P = 32,
  parameter int SINE_TABLE_BITS      = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  mfsk_in_if.sink     in_ch,
  mfsk_out_if.source  out_ch,
  mfsk_cfg_if.sink    cfg_ch
);

  mfsk_cfg_t  cfg;
  mfsk_cmd_t  cmd;
  mfsk_stat_t stat;

  // Registers are always writable
  assign cfg_ch.ready = 1'b1;

  mfsk_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  mfsk_ctrl #(
    .SAMPLES_PER_SYMBOL_P (SAMPLES_PER_SYMBOL_P)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.data_byte),
    .tone_count (cfg.tone_count),
    .stat       (stat),
    .cmd        (cmd)
  );

  mfsk_dp #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_sample (out_ch.sample),
    .out_tone   (out_ch.tone_index),
    .out_last   (out_ch.last)
  );

endmodule

>>> rtl/core/mfsk_checker.sv
// Port-level checker for the MFSK modulator and its bind
`timescale 1ns / 1ps
`include "mfsk_continuous_phase_modulator_assert.svh"
module mfsk_port_checker #(
  parameter int SAMPLES_PER_SYMBOL_P = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample,
  input logic [3:0]  out_tone,
  input logic        out_last
);

  localparam int TOT    = 2 * SAMPLES_PER_SYMBOL_P;
  localparam int OCNT_W = $clog2(TOT);
  localparam int SCNT_W = (SAMPLES_PER_SYMBOL_P > 1) ? $clog2(SAMPLES_PER_SYMBOL_P) : 1;

  logic              in_fire;
  logic              out_fire;
  logic              out_stall;
  logic [20:0]       out_payload;
  logic [OCNT_W-1:0] ocnt_r;
  logic [SCNT_W-1:0] scnt_r;
  logic [3:0]        tone_r;
  logic [3:0]        pend_r;

  assign in_fire     = in_valid && in_ready;
  assign out_fire    = out_valid && out_ready;
  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_sample, out_tone, out_last};

  // Track position of each output item within its byte and symbol
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
      scnt_r <= '0;
      pend_r <= '0;
    end else begin
      if (out_fire) begin
        ocnt_r <= (ocnt_r == OCNT_W'(TOT - 1)) ? '0 : ocnt_r + 1'b1;
        scnt_r <= (scnt_r == SCNT_W'(SAMPLES_PER_SYMBOL_P - 1)) ? '0 : scnt_r + 1'b1;
      end
      pend_r <= pend_r + 4'(in_fire) - 4'(out_fire && out_last);
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      tone_r <= out_tone;
    end
  end

  `MFSK_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload))
  `MFSK_ASSERT_NOW(a_last_place, out_fire, out_last == (ocnt_r == OCNT_W'(TOT - 1)))
  `MFSK_ASSERT_NOW(a_tone_steady, out_fire && (scnt_r != '0), out_tone == tone_r)
  `MFSK_ASSERT_NOW(a_no_orphan, out_valid, pend_r != 4'd0)

endmodule

bind mfsk_continuous_phase_modulator mfsk_port_checker #(
  .SAMPLES_PER_SYMBOL_P (SAMPLES_PER_SYMBOL_P)
) u_mfsk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample),
  .out_tone   (out_ch.tone_index),
  .out_last   (out_ch.last)
);
